>>> rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared widths, constants, divider lane type and per-stage helper functions
// for the segment intersection point core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

	localparam int COORD_W = 32;            // Q16.16 coordinate
	localparam int DIFF_W  = COORD_W + 1;   // coordinate difference
	localparam int PROD_W  = 2 * DIFF_W;    // difference product
	localparam int CROSS_W = PROD_W + 1;    // cross product
	localparam int MAG_W   = 65;            // |cross| < 2^65
	localparam int KMAG_W  = 32;            // |segment delta| < 2^32
	localparam int PLO_W   = 32;            // low slice of |num| per partial product
	localparam int PPLO_W  = KMAG_W + PLO_W;
	localparam int PPHI_W  = KMAG_W + MAG_W - PLO_W;
	localparam int AN_W    = KMAG_W + MAG_W;  // |k * num|
	localparam int NUM_W   = AN_W + 2;        // 2|k*num| + |den|
	localparam int DEN2_W  = MAG_W + 1;       // 2|den|
	localparam int QBITS   = 42;              // quotient bits resolved
	localparam int REM_W   = DEN2_W + 1;
	localparam int OFF_W   = 41;              // offset up to 2^40
	localparam int SUM_W   = OFF_W + 2;

	localparam int COORD_FRAC_BITS = 16;

	localparam longint MISS_RAW = -64'sd42 * (64'sd1 <<< COORD_FRAC_BITS);
	localparam logic signed [COORD_W-1:0] MISS_COORD =
		(MISS_RAW < -64'sd2147483648) ? 32'sh8000_0000 : MISS_RAW[COORD_W-1:0];

	localparam logic [OFF_W-1:0] OFF_CAP = OFF_W'(1) << (OFF_W - 1);

	// one coordinate lane of the long divider
	typedef struct packed {
		logic [DEN2_W-1:0]  r;
		logic [QBITS-1:0]   nlo;
		logic [DEN2_W-1:0]  d;
		logic [QBITS-1:0]   q;
		logic               ovf;
		logic               neg;
		logic [COORD_W-1:0] base;
	} div_lane_t;

	// one restoring step: resolves one quotient bit, MSB first
	function automatic div_lane_t div_step(div_lane_t x);
		div_lane_t y;
		logic [REM_W-1:0] t;
		y = x;
		t = {x.r, x.nlo[QBITS-1]};
		y.nlo = {x.nlo[QBITS-2:0], 1'b0};
		if (t >= {1'b0, x.d}) begin
			y.r = DEN2_W'(t - {1'b0, x.d});
			y.q = {x.q[QBITS-2:0], 1'b1};
		end else begin
			y.r = t[DEN2_W-1:0];
			y.q = {x.q[QBITS-2:0], 1'b0};
		end
		return y;
	endfunction

	// base + signed, clamped offset, saturated to 32 bits
	function automatic logic [COORD_W-1:0] lane_result(div_lane_t x);
		logic [OFF_W-1:0] off;
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] base_ext;
		if (x.ovf || (x.q > QBITS'(OFF_CAP)))
			off = OFF_CAP;
		else
			off = x.q[OFF_W-1:0];
		base_ext = SUM_W'(signed'(x.base));
		if (x.neg)
			sum = base_ext - signed'({2'b00, off});
		else
			sum = base_ext + signed'({2'b00, off});
		if (sum > SUM_W'(64'sd2147483647))
			return 32'h7FFF_FFFF;
		else if (sum < SUM_W'(-64'sd2147483648))
			return 32'h8000_0000;
		else
			return sum[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/segment_intersection_point_core.sv
// Throughput: one item per cycle while the output is not stalled; the
// 42-step pipelined divider per coordinate sets the depth, each step resolving
// one quotient bit.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// segment_intersection_point_core
// Bounding box and orientation test on two segments, then the exact meeting
// point of the carrying lines, rounded and saturated to Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_point_core
	import sip_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [COORD_W-1:0] a_start_x,
	input  wire logic signed [COORD_W-1:0] a_start_y,
	input  wire logic signed [COORD_W-1:0] a_end_x,
	input  wire logic signed [COORD_W-1:0] a_end_y,
	input  wire logic signed [COORD_W-1:0] b_start_x,
	input  wire logic signed [COORD_W-1:0] b_start_y,
	input  wire logic signed [COORD_W-1:0] b_end_x,
	input  wire logic signed [COORD_W-1:0] b_end_y,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           hit,
	output logic signed [COORD_W-1:0]      cross_x,
	output logic signed [COORD_W-1:0]      cross_y
);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------- stage 1: differences and box test ----------------
	logic box_c;
	logic signed [COORD_W-1:0] ax_max, ax_min, ay_max, ay_min;
	logic signed [COORD_W-1:0] bx_max, bx_min, by_max, by_min;

	always_comb begin
		ax_max = (a_start_x > a_end_x) ? a_start_x : a_end_x;
		ax_min = (a_start_x < a_end_x) ? a_start_x : a_end_x;
		ay_max = (a_start_y > a_end_y) ? a_start_y : a_end_y;
		ay_min = (a_start_y < a_end_y) ? a_start_y : a_end_y;
		bx_max = (b_start_x > b_end_x) ? b_start_x : b_end_x;
		bx_min = (b_start_x < b_end_x) ? b_start_x : b_end_x;
		by_max = (b_start_y > b_end_y) ? b_start_y : b_end_y;
		by_min = (b_start_y < b_end_y) ? b_start_y : b_end_y;
		box_c  = (ax_max >= bx_min) && (bx_max >= ax_min) &&
		         (ay_max >= by_min) && (by_max >= ay_min);
	end

	logic vld_s1, box_s1;
	logic signed [DIFF_W-1:0] dxa_s1, dya_s1, dxb_s1, dyb_s1;
	logic signed [DIFF_W-1:0] ux13_s1, uy13_s1, ux14_s1, uy14_s1, ux32_s1, uy32_s1;
	logic [COORD_W-1:0] bx_s1, by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s1  <= box_c;
			dxa_s1  <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
			dya_s1  <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
			dxb_s1  <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
			dyb_s1  <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
			ux13_s1 <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
			uy13_s1 <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);
			ux14_s1 <= DIFF_W'(b_end_x) - DIFF_W'(a_start_x);
			uy14_s1 <= DIFF_W'(b_end_y) - DIFF_W'(a_start_y);
			ux32_s1 <= DIFF_W'(a_end_x) - DIFF_W'(b_start_x);
			uy32_s1 <= DIFF_W'(a_end_y) - DIFF_W'(b_start_y);
			bx_s1   <= a_start_x;
			by_s1   <= a_start_y;
		end
	end

	// ---------------- stage 2: ten products ----------------
	// the orientation of A's start against B equals the numerator
	logic vld_s2, box_s2;
	logic signed [PROD_W-1:0] o1a_s2, o1b_s2, o2a_s2, o2b_s2, o4a_s2, o4b_s2;
	logic signed [PROD_W-1:0] na_s2, nb_s2, da_s2, db_s2;
	logic signed [DIFF_W-1:0] dxa_s2, dya_s2;
	logic [COORD_W-1:0] bx_s2, by_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s2 <= box_s1;
			o1a_s2 <= uy13_s1 * dxa_s1;
			o1b_s2 <= ux13_s1 * dya_s1;
			o2a_s2 <= uy14_s1 * dxa_s1;
			o2b_s2 <= ux14_s1 * dya_s1;
			o4a_s2 <= uy32_s1 * dxb_s1;
			o4b_s2 <= ux32_s1 * dyb_s1;
			na_s2  <= ux13_s1 * dyb_s1;
			nb_s2  <= uy13_s1 * dxb_s1;
			da_s2  <= dxa_s1 * dyb_s1;
			db_s2  <= dya_s1 * dxb_s1;
			dxa_s2 <= dxa_s1;
			dya_s2 <= dya_s1;
			bx_s2  <= bx_s1;
			by_s2  <= by_s1;
		end
	end

	// ---------------- stage 3: cross products, hit, magnitudes ----------------
	logic signed [CROSS_W-1:0] o1_c, o2_c, o4_c, num_c, den_c, nneg_c, dneg_c;
	logic hit_c;

	always_comb begin
		o1_c   = CROSS_W'(o1a_s2) - CROSS_W'(o1b_s2);
		o2_c   = CROSS_W'(o2a_s2) - CROSS_W'(o2b_s2);
		o4_c   = CROSS_W'(o4a_s2) - CROSS_W'(o4b_s2);
		num_c  = CROSS_W'(na_s2) - CROSS_W'(nb_s2);
		den_c  = CROSS_W'(da_s2) - CROSS_W'(db_s2);
		nneg_c = -num_c;
		dneg_c = -den_c;
		hit_c  = box_s2 &&
		         ((!o1_c[CROSS_W-1] && o1_c != '0) != (!o2_c[CROSS_W-1] && o2_c != '0)) &&
		         ((!num_c[CROSS_W-1] && num_c != '0) != (!o4_c[CROSS_W-1] && o4_c != '0)) &&
		         (den_c != '0);
	end

	logic vld_s3, hit_s3, nsgn_s3, dsgn_s3;
	logic [MAG_W-1:0] nmag_s3, dmag_s3;
	logic [KMAG_W-1:0] kmag_s3 [2];
	logic ksgn_s3 [2];
	logic [COORD_W-1:0] base_s3 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3     <= hit_c;
			nsgn_s3    <= num_c[CROSS_W-1];
			dsgn_s3    <= den_c[CROSS_W-1];
			nmag_s3    <= num_c[CROSS_W-1] ? nneg_c[MAG_W-1:0] : num_c[MAG_W-1:0];
			dmag_s3    <= den_c[CROSS_W-1] ? dneg_c[MAG_W-1:0] : den_c[MAG_W-1:0];
			ksgn_s3[0] <= dxa_s2[DIFF_W-1];
			ksgn_s3[1] <= dya_s2[DIFF_W-1];
			kmag_s3[0] <= dxa_s2[DIFF_W-1] ? KMAG_W'(-dxa_s2) : KMAG_W'(dxa_s2);
			kmag_s3[1] <= dya_s2[DIFF_W-1] ? KMAG_W'(-dya_s2) : KMAG_W'(dya_s2);
			base_s3[0] <= bx_s2;
			base_s3[1] <= by_s2;
		end
	end

	// ---------------- stage 4: partial products of |k| * |num| ----------------
	logic vld_s4, hit_s4;
	logic [MAG_W-1:0] dmag_s4;
	logic [PPLO_W-1:0] pplo_s4 [2];
	logic [PPHI_W-1:0] pphi_s4 [2];
	logic neg_s4 [2];
	logic [COORD_W-1:0] base_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= hit_s3;
			dmag_s4 <= dmag_s3;
			for (int l = 0; l < 2; l++) begin
				pplo_s4[l] <= PPLO_W'(kmag_s3[l]) * PPLO_W'(nmag_s3[PLO_W-1:0]);
				pphi_s4[l] <= PPHI_W'(kmag_s3[l]) * PPHI_W'(nmag_s3[MAG_W-1:PLO_W]);
				neg_s4[l]  <= ksgn_s3[l] ^ nsgn_s3 ^ dsgn_s3;
				base_s4[l] <= base_s3[l];
			end
		end
	end

	// ---------------- stage 5: product sum ----------------
	logic vld_s5, hit_s5;
	logic [MAG_W-1:0] dmag_s5;
	logic [AN_W-1:0] an_s5 [2];
	logic neg_s5 [2];
	logic [COORD_W-1:0] base_s5 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5  <= hit_s4;
			dmag_s5 <= dmag_s4;
			for (int l = 0; l < 2; l++) begin
				an_s5[l]   <= AN_W'(pplo_s4[l]) + {pphi_s4[l], {PLO_W{1'b0}}};
				neg_s5[l]  <= neg_s4[l];
				base_s5[l] <= base_s4[l];
			end
		end
	end

	// ---------------- stage 6: rounding dividend and divisor ----------------
	logic vld_s6, hit_s6;
	logic [DEN2_W-1:0] d_s6;
	logic [NUM_W-1:0] n_s6 [2];
	logic neg_s6 [2];
	logic [COORD_W-1:0] base_s6 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6 <= hit_s5;
			d_s6   <= {dmag_s5, 1'b0};
			for (int l = 0; l < 2; l++) begin
				n_s6[l]    <= NUM_W'({an_s5[l], 1'b0}) + NUM_W'(dmag_s5);
				neg_s6[l]  <= neg_s5[l];
				base_s6[l] <= base_s5[l];
			end
		end
	end

	// ---------------- stage 7 and divider: one quotient bit per stage ----------------
	// dv_s[0] is the loaded divider state; dv_s[QBITS] holds the full quotient
	logic       dv_vld_s [QBITS+1];
	logic       dv_hit_s [QBITS+1];
	div_lane_t  dv_s     [QBITS+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QBITS; i++) dv_vld_s[i] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= vld_s6;
			for (int i = 0; i < QBITS; i++) dv_vld_s[i+1] <= dv_vld_s[i];
		end
	end

	// quotient of 2^42 or more goes straight to the clamp
	always_ff @(posedge clk) begin
		if (en) begin
			dv_hit_s[0] <= hit_s6;
			for (int l = 0; l < 2; l++) begin
				dv_s[0][l].ovf  <= DEN2_W'(n_s6[l][NUM_W-1:QBITS]) >= d_s6;
				dv_s[0][l].r    <= (DEN2_W'(n_s6[l][NUM_W-1:QBITS]) >= d_s6) ?
				                   '0 : DEN2_W'(n_s6[l][NUM_W-1:QBITS]);
				dv_s[0][l].nlo  <= n_s6[l][QBITS-1:0];
				dv_s[0][l].d    <= d_s6;
				dv_s[0][l].q    <= '0;
				dv_s[0][l].neg  <= neg_s6[l];
				dv_s[0][l].base <= base_s6[l];
			end
			for (int i = 0; i < QBITS; i++) begin
				dv_hit_s[i+1] <= dv_hit_s[i];
				for (int l = 0; l < 2; l++) dv_s[i+1][l] <= div_step(dv_s[i][l]);
			end
		end
	end

	// ---------------- output register: clamp, add, saturate ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_vld_s[QBITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= dv_hit_s[QBITS];
			cross_x <= dv_hit_s[QBITS] ? lane_result(dv_s[QBITS][0]) : MISS_COORD;
			cross_y <= dv_hit_s[QBITS] ? lane_result(dv_s[QBITS][1]) : MISS_COORD;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks on the segment intersection point core, bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sip_checker
	import sip_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic                      hit,
	input wire logic signed [COORD_W-1:0] cross_x,
	input wire logic signed [COORD_W-1:0] cross_y
);

	// reset empties the pipeline by the next edge
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("item shown during reset");

	// input only backs up behind a stalled output item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output stall");

	// a miss always carries the fixed miss coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (cross_x == MISS_COORD && cross_y == MISS_COORD))
		else $error("miss item with wrong coordinates");

	// stalled output item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(hit) && $stable(cross_x) && $stable(cross_y)))
		else $error("stalled output item changed");

endmodule

bind segment_intersection_point_core sip_checker u_sip_checker (.*);

`default_nettype wire
